/* src/khtc_pkg.sv */
// Shared types, constants and the CRC byte-update function for the hash-tag slot block.
// No dependencies; every other file in src imports this package.
package khtc_pkg;

  localparam int unsigned CRC_W      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned CNT_REG_W  = 11;
  localparam int unsigned SLOT_LIMIT = 1024;
  localparam int unsigned DIV_CNT_W  = $clog2(CRC_W);

  localparam logic [CRC_W-1:0]  CRC_POLY    = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]  CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0] OPEN_BRACE  = 8'h7B;
  localparam logic [BYTE_W-1:0] CLOSE_BRACE = 8'h7D;

  // Queue between front and back; depth must be a power of two
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  // APB register map
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;
  localparam logic [0:0]  REG_SLOT_COUNT = 1'b0;
  localparam logic [CNT_REG_W-1:0] SLOT_COUNT_RST = 11'd1024;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              no_byte;
    logic              last;
  } key_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CRC_W-1:0]  checksum;
    logic              has_tag;
  } slot_out_t;

  typedef struct packed {
    logic [CRC_W-1:0] checksum;
    logic             has_tag;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Reflected CRC-32 update by one byte, LSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* src/key_hash_tag_crc32_slot.sv */
// Hash-tag CRC-32 slot selector, top level. A result is valid once the last byte's
// transfer has passed the queue pop, 32 modulo steps and the output load. Throughput:
// one key byte per cycle at the front while the queue is not full; the back takes one
// key at a time, set by the bit-serial modulo unit, and pops the next only once the
// result is loaded. A two-entry queue absorbs short keys. Reset: async active low;
// clears CRCs to all ones, tag phase, queue, and sets slot_count to 1024.
module key_hash_tag_crc32_slot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // key byte channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  khtc_pkg::key_in_t              in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output khtc_pkg::slot_out_t            out_data_o,
  // APB config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [khtc_pkg::APB_AW-1:0]    paddr,
  input  logic [khtc_pkg::APB_DW-1:0]    pwdata,
  output logic [khtc_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import khtc_pkg::*;

  logic [CNT_REG_W-1:0] slot_count_q, slot_count_d;
  logic                 cfg_wr;
  logic [0:0]           reg_idx;

  q_stat_t  q_stat;
  q_entry_t q_push_data, q_pop_data;
  logic     q_push, q_pop;

  // Config: single word register at byte address 0; other words read zero
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    slot_count_d = slot_count_q;
    if (cfg_wr && reg_idx == REG_SLOT_COUNT) slot_count_d = pwdata[CNT_REG_W-1:0];
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SLOT_COUNT) prdata = {{(APB_DW-CNT_REG_W){1'b0}}, slot_count_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
    end else begin
      slot_count_q <= slot_count_d;
    end
  end

  // Front: CRC per byte transfer, brace tracking, one queue entry per key
  khtc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  khtc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .stat_o      (q_stat)
  );

  // Back: modulo by slot count and output register
  khtc_mod u_mod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .q_data_i     (q_pop_data),
    .q_pop_o      (q_pop),
    .slot_count_i (slot_count_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  // slot must lie below the effective slot count
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.slot} < slot_count_q ||
                     slot_count_q > CNT_REG_W'(SLOT_LIMIT) ||
                     (slot_count_q == '0 && out_data_o.slot == '0)))
    else $error("slot out of range");

  // queue cannot report full and empty together
  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // a key-end transfer lands in the queue: it is non-empty next cycle
  a_q_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> !q_stat.empty)
    else $error("queue lost an entry");
`endif

endmodule

/* src/khtc_front.sv */
// Front end: takes key bytes, runs whole-key and tag CRCs, tracks the brace phase.
// Pushes one finished checksum per key into the queue. Depends on khtc_pkg.
module khtc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  khtc_pkg::key_in_t  in_data_i,
  input  khtc_pkg::q_stat_t  q_stat_i,
  output logic               q_push_o,
  output khtc_pkg::q_entry_t q_data_o
);
  import khtc_pkg::*;

  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_TAG  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]       phase_q, phase_d, phase_nx;
  logic [CRC_W-1:0] whole_q, whole_d, whole_nx;
  logic [CRC_W-1:0] tag_q, tag_d, tag_nx;
  logic             accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    phase_nx = phase_q;
    whole_nx = whole_q;
    tag_nx   = tag_q;
    if (!in_data_i.no_byte) begin
      whole_nx = crc_byte(whole_q, in_data_i.key_byte);
      case (phase_q)
        PH_PRE: begin
          if (in_data_i.key_byte == OPEN_BRACE) phase_nx = PH_TAG;
        end
        PH_TAG: begin
          if (in_data_i.key_byte == CLOSE_BRACE) phase_nx = PH_DONE;
          else tag_nx = crc_byte(tag_q, in_data_i.key_byte);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    whole_d = whole_q;
    tag_d   = tag_q;
    if (accept) begin
      if (in_data_i.last) begin
        phase_d = PH_PRE;
        whole_d = CRC_INIT;
        tag_d   = CRC_INIT;
      end else begin
        phase_d = phase_nx;
        whole_d = whole_nx;
        tag_d   = tag_nx;
      end
    end
  end

  assign q_push_o          = accept & in_data_i.last;
  assign q_data_o.has_tag  = (phase_nx == PH_DONE);
  assign q_data_o.checksum = (phase_nx == PH_DONE) ? ~tag_nx : ~whole_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PRE;
      whole_q <= CRC_INIT;
      tag_q   <= CRC_INIT;
    end else begin
      phase_q <= phase_d;
      whole_q <= whole_d;
      tag_q   <= tag_d;
    end
  end

endmodule

/* src/khtc_queue.sv */
// Short FIFO of finished checksums between the front end and the modulo back end.
// Register based, depth from khtc_pkg::Q_DEPTH. Depends on khtc_pkg.
module khtc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  khtc_pkg::q_entry_t push_data_i,
  input  logic               pop_i,
  output khtc_pkg::q_entry_t pop_data_o,
  output khtc_pkg::q_stat_t  stat_o
);
  import khtc_pkg::*;

  q_entry_t      mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* src/khtc_mod.sv */
// Back end: bit-serial restoring modulo of the checksum by the slot count, plus
// the output register. One quotient bit per cycle. Depends on khtc_pkg.
module khtc_mod (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  khtc_pkg::q_stat_t                 q_stat_i,
  input  khtc_pkg::q_entry_t                q_data_i,
  output logic                              q_pop_o,
  input  logic [khtc_pkg::CNT_REG_W-1:0]    slot_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output khtc_pkg::slot_out_t               out_data_o
);
  import khtc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CRC_W-1:0]     dvd_q, dvd_d;
  logic [CNT_REG_W-1:0] rem_q, rem_d, rem_sh, mod_q, mod_d, mod_eff;
  q_entry_t             ent_q, ent_d;
  logic                 out_valid_q, out_valid_d;
  slot_out_t            out_q, out_d;

  // zero counts as one, large counts saturate
  always_comb begin
    mod_eff = slot_count_i;
    if (slot_count_i == '0) mod_eff = CNT_REG_W'(1);
    else if (slot_count_i > CNT_REG_W'(SLOT_LIMIT)) mod_eff = CNT_REG_W'(SLOT_LIMIT);
  end

  assign rem_sh  = {rem_q[CNT_REG_W-2:0], dvd_q[CRC_W-1]};
  assign q_pop_o = (state_q == ST_IDLE) & ~q_stat_i.empty;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    mod_d       = mod_q;
    ent_d       = ent_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          ent_d   = q_data_i;
          dvd_d   = q_data_i.checksum;
          rem_d   = '0;
          cnt_d   = '0;
          mod_d   = mod_eff;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = (rem_sh >= mod_q) ? rem_sh - mod_q : rem_sh;
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(CRC_W-1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.slot       = rem_q[SLOT_W-1:0];
          out_d.checksum   = ent_q.checksum;
          out_d.has_tag    = ent_q.has_tag;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    mod_q <= mod_d;
    ent_q <= ent_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
